FILE: design/tlvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvp_pkg: shared types and constants of the TLV record stream parser
// Transaction payloads, configuration set, byte role and status codes.
// ----------------------------------------------------------------------------
package tlvp_pkg;

	localparam int HEADER_BYTES = 6;
	localparam int HDR_POS_W    = $clog2(HEADER_BYTES);
	localparam int PREAMBLE_BYTES = 3;

	localparam logic [15:0] MAX_LEN_RESET  = 16'd1586;
	localparam logic [23:0] PREAMBLE_RESET = 24'h4B4E47;

	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD_LENGTH = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_WORD      = 8'd1;

	localparam logic [2:0] ROLE_HEADER   = 3'd0;
	localparam logic [2:0] ROLE_CATEGORY = 3'd1;
	localparam logic [2:0] ROLE_PARAM    = 3'd2;
	localparam logic [2:0] ROLE_LEN_HI   = 3'd3;
	localparam logic [2:0] ROLE_LEN_LO   = 3'd4;
	localparam logic [2:0] ROLE_PAYLOAD  = 3'd5;
	localparam logic [2:0] ROLE_IGNORED  = 3'd6;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_OVER_LIMIT = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_CAT     = 6'b000010,
		PH_PARAM   = 6'b000100,
		PH_LENHI   = 6'b001000,
		PH_LENLO   = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  byte_role;
		logic        record_done;
		logic [16:0] record_total_length;
		logic        header_match;
		logic [1:0]  parse_status;
		logic        stream_done;
		logic        sum_zero;
	} result_t;

	typedef struct packed {
		logic [15:0] max_payload_length;
		logic [23:0] preamble_word;
	} cfg_t;

endpackage
`default_nettype wire

FILE: design/tlvp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvp_cfg_regs: configuration register file
// Holds the payload length limit and the expected preamble.
// ----------------------------------------------------------------------------
module tlvp_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [tlvp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [23:0]                      cfg_data,
	output      tlvp_pkg::cfg_t                   cfg
);

	tlvp_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Drop writes to indexes beyond the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_length <= tlvp_pkg::MAX_LEN_RESET;
			cfg_q.preamble_word      <= tlvp_pkg::PREAMBLE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == tlvp_pkg::REG_MAX_PAYLOAD_LENGTH) begin
				cfg_q.max_payload_length <= cfg_data[15:0];
			end else if (cfg_index == tlvp_pkg::REG_PREAMBLE_WORD) begin
				cfg_q.preamble_word <= cfg_data;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/tlvp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvp_parse_core: parse state and per-byte decode
// Computes one result from the current byte and advances the parse state.
// ----------------------------------------------------------------------------
module tlvp_parse_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire tlvp_pkg::item_t  item,
	input  wire tlvp_pkg::cfg_t   cfg,
	output      tlvp_pkg::result_t result
);

	tlvp_pkg::phase_t               phase_q, phase_d;
	logic [tlvp_pkg::HDR_POS_W-1:0] hpos_q, hpos_d;
	logic [15:0]                    remain_q, remain_d;
	logic [7:0]                     len_hi_q, len_hi_d;
	logic [15:0]                    cur_len_q, cur_len_d;
	logic [7:0]                     sum_q, sum_d;
	logic                           pre_ok_q, pre_ok_d;
	logic                           stop_q, stop_d;

	logic [7:0]  b;
	logic [7:0]  want;
	logic [15:0] len_word;
	logic [15:0] remain_dec;

	assign b          = item.data_byte;
	assign len_word   = {len_hi_q, b};
	assign remain_dec = remain_q - 16'd1;

	always_comb begin
		case (hpos_q)
			tlvp_pkg::HDR_POS_W'(0): want = cfg.preamble_word[23:16];
			tlvp_pkg::HDR_POS_W'(1): want = cfg.preamble_word[15:8];
			default:                 want = cfg.preamble_word[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		hpos_d    = hpos_q;
		remain_d  = remain_q;
		len_hi_d  = len_hi_q;
		cur_len_d = cur_len_q;
		sum_d     = sum_q + b;
		pre_ok_d  = pre_ok_q;
		stop_d    = stop_q;

		result.byte_out            = b;
		result.byte_role           = tlvp_pkg::ROLE_IGNORED;
		result.record_done         = 1'b0;
		result.record_total_length = 17'd0;

		if (!stop_q) begin
			case (phase_q)
				tlvp_pkg::PH_HEADER: begin
					result.byte_role = tlvp_pkg::ROLE_HEADER;
					if ({{(32-tlvp_pkg::HDR_POS_W){1'b0}}, hpos_q} < tlvp_pkg::PREAMBLE_BYTES
					    && want != b) begin
						pre_ok_d = 1'b0;
					end
					if (hpos_q == tlvp_pkg::HDR_POS_W'(tlvp_pkg::HEADER_BYTES - 1)) begin
						hpos_d  = '0;
						phase_d = tlvp_pkg::PH_CAT;
					end else begin
						hpos_d = hpos_q + 1'b1;
					end
				end
				tlvp_pkg::PH_CAT: begin
					result.byte_role = tlvp_pkg::ROLE_CATEGORY;
					phase_d          = tlvp_pkg::PH_PARAM;
				end
				tlvp_pkg::PH_PARAM: begin
					result.byte_role = tlvp_pkg::ROLE_PARAM;
					phase_d          = tlvp_pkg::PH_LENHI;
				end
				tlvp_pkg::PH_LENHI: begin
					result.byte_role = tlvp_pkg::ROLE_LEN_HI;
					len_hi_d         = b;
					phase_d          = tlvp_pkg::PH_LENLO;
				end
				tlvp_pkg::PH_LENLO: begin
					result.byte_role = tlvp_pkg::ROLE_LEN_LO;
					cur_len_d        = len_word;
					if (len_word > cfg.max_payload_length) begin
						stop_d = 1'b1;
					end else if (len_word == 16'd0) begin
						result.record_done         = 1'b1;
						result.record_total_length = 17'd4;
						phase_d                    = tlvp_pkg::PH_CAT;
					end else begin
						remain_d = len_word;
						phase_d  = tlvp_pkg::PH_PAYLOAD;
					end
				end
				default: begin
					result.byte_role = tlvp_pkg::ROLE_PAYLOAD;
					remain_d         = remain_dec;
					if (remain_dec == 16'd0) begin
						result.record_done         = 1'b1;
						result.record_total_length = {1'b0, cur_len_q} + 17'd4;
						phase_d                    = tlvp_pkg::PH_CAT;
					end
				end
			endcase
		end

		result.header_match = pre_ok_d;
		result.stream_done  = item.end_of_stream;
		result.sum_zero     = item.end_of_stream && (sum_d == 8'd0);
		if (stop_d) begin
			result.parse_status = tlvp_pkg::STATUS_OVER_LIMIT;
		end else if (item.end_of_stream && phase_d != tlvp_pkg::PH_CAT) begin
			result.parse_status = tlvp_pkg::STATUS_TRUNCATED;
		end else begin
			result.parse_status = tlvp_pkg::STATUS_OK;
		end
	end

	// Advance on each consumed byte; return to the start state after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tlvp_pkg::PH_HEADER;
			hpos_q    <= '0;
			remain_q  <= '0;
			len_hi_q  <= '0;
			cur_len_q <= '0;
			sum_q     <= '0;
			pre_ok_q  <= 1'b1;
			stop_q    <= 1'b0;
		end else if (step) begin
			if (item.end_of_stream) begin
				phase_q   <= tlvp_pkg::PH_HEADER;
				hpos_q    <= '0;
				remain_q  <= '0;
				len_hi_q  <= '0;
				cur_len_q <= '0;
				sum_q     <= '0;
				pre_ok_q  <= 1'b1;
				stop_q    <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				hpos_q    <= hpos_d;
				remain_q  <= remain_d;
				len_hi_q  <= len_hi_d;
				cur_len_q <= cur_len_d;
				sum_q     <= sum_d;
				pre_ok_q  <= pre_ok_d;
				stop_q    <= stop_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/tlv_record_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_record_stream_parser_unit: TLV record deframer with additive checksum
// Tags each stream byte with its role, reports record lengths, preamble match,
// length-limit errors, truncation and the end-of-stream checksum result.
// ----------------------------------------------------------------------------
// The unit takes one byte transaction per clock while results are taken and
// returns exactly one result transaction per byte, in order. A byte sits in the
// input register while it is decoded and moves into the result register, from
// which its result is offered. The rate of one byte per cycle is set by the
// single decode step between those two registers, which updates the parse
// state as the byte moves forward. While a result waits in the result register
// a new byte is still taken as long as the input register is empty; with both
// registers full the byte side stalls until the result is taken.
// Configuration writes are always accepted; write them only while no stream
// byte is in flight. After the final byte the parse state returns to its reset
// values while the configuration registers keep their contents.
// ----------------------------------------------------------------------------
module tlv_record_stream_parser_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output      logic                             item_ready,
	input  wire tlvp_pkg::item_t                  item,
	output      logic                             result_valid,
	input  wire logic                             result_ready,
	output      tlvp_pkg::result_t                result,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [tlvp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [23:0]                      cfg_data
);

	tlvp_pkg::cfg_t    cfg;
	tlvp_pkg::item_t   item_s1;
	logic              valid_s1;
	tlvp_pkg::result_t decoded;
	tlvp_pkg::result_t result_s2;
	logic              valid_s2;
	logic              out_free;
	logic              advance;

	// Result register is free when empty or being taken this cycle.
	assign out_free   = !valid_s2 || result_ready;
	// Move the held byte through decode into the result register.
	assign advance    = valid_s1 && out_free;
	// Accept a new byte whenever the input register empties or is empty.
	assign item_ready = !valid_s1 || out_free;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	tlvp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tlvp_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (decoded)
	);

	// Input register: hold the byte until decode consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result register: hold the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= decoded;
		end
	end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the TLV record stream parser unit
// Drives byte streams through valid/ready handshakes with random idling on
// both sides, predicts the tag of every byte in step with the parser state and
// compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb;

	// Index past the end of the register map; writes to it must be dropped.
	localparam logic [tlvp_pkg::CFG_INDEX_W-1:0] REG_UNUSED =
		tlvp_pkg::REG_PREAMBLE_WORD + 1'b1;
	// Last header byte: not part of the preamble, so free for checksum fixing.
	localparam int FREE_HDR_BYTE = tlvp_pkg::HEADER_BYTES - 1;
	localparam int SEGMENT_ITEMS = 245;
	// Two register stages inside the unit; the drain idles on past them.
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] byte_q_t[$];

	logic clk;
	logic arst_n = 1'b0;

	logic              item_valid = 1'b0;
	logic              item_ready;
	tlvp_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	tlvp_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [tlvp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [23:0]       cfg_data = '0;

	tlv_record_stream_parser_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard: far beyond the slowest legal run of this stimulus.
	initial begin
		#(5_000_000);
		$display("** tlv_record_stream_parser_unit: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Parser shadow: configuration copy and per-stream parse state
	// ------------------------------------------------------------------------
	logic [15:0] cfg_max_len  = tlvp_pkg::MAX_LEN_RESET;
	logic [23:0] cfg_preamble = tlvp_pkg::PREAMBLE_RESET;

	tlvp_pkg::phase_t phase = tlvp_pkg::PH_HEADER;
	int          hdr_pos   = 0;
	logic [15:0] pay_left  = '0;
	logic [15:0] pay_len   = '0;
	logic [7:0]  len_hi    = '0;
	logic [7:0]  run_sum   = '0;
	logic        pre_ok    = 1'b1;
	logic        halted    = 1'b0;

	tlvp_pkg::result_t due_tags[$];
	tlvp_pkg::result_t head_tag;
	int          items_sent = 0;
	int          mismatches = 0;
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;

	// Tag one accepted byte and advance the shadow parse state.
	function automatic tlvp_pkg::result_t tag_byte(input logic [7:0] b, input logic eos);
		tlvp_pkg::result_t r;
		logic [15:0] len;
		r = '0;
		r.byte_out    = b;
		r.byte_role   = tlvp_pkg::ROLE_IGNORED;
		r.stream_done = eos;
		run_sum = run_sum + b;
		if (!halted) begin
			case (phase)
				tlvp_pkg::PH_HEADER: begin
					r.byte_role = tlvp_pkg::ROLE_HEADER;
					if (hdr_pos < tlvp_pkg::PREAMBLE_BYTES &&
						cfg_preamble[(tlvp_pkg::PREAMBLE_BYTES - 1 - hdr_pos) * 8 +: 8] != b)
						pre_ok = 1'b0;
					hdr_pos++;
					if (hdr_pos >= tlvp_pkg::HEADER_BYTES) begin
						hdr_pos = 0;
						phase = tlvp_pkg::PH_CAT;
					end
				end
				tlvp_pkg::PH_CAT: begin
					r.byte_role = tlvp_pkg::ROLE_CATEGORY;
					phase = tlvp_pkg::PH_PARAM;
				end
				tlvp_pkg::PH_PARAM: begin
					r.byte_role = tlvp_pkg::ROLE_PARAM;
					phase = tlvp_pkg::PH_LENHI;
				end
				tlvp_pkg::PH_LENHI: begin
					r.byte_role = tlvp_pkg::ROLE_LEN_HI;
					len_hi = b;
					phase = tlvp_pkg::PH_LENLO;
				end
				tlvp_pkg::PH_LENLO: begin
					r.byte_role = tlvp_pkg::ROLE_LEN_LO;
					len = {len_hi, b};
					pay_len = len;
					if (len > cfg_max_len) begin
						halted = 1'b1;
					end else if (len == 16'd0) begin
						r.record_done = 1'b1;
						r.record_total_length = 17'd4;
						phase = tlvp_pkg::PH_CAT;
					end else begin
						pay_left = len;
						phase = tlvp_pkg::PH_PAYLOAD;
					end
				end
				default: begin
					r.byte_role = tlvp_pkg::ROLE_PAYLOAD;
					pay_left = pay_left - 16'd1;
					if (pay_left == 16'd0) begin
						r.record_done = 1'b1;
						r.record_total_length = {1'b0, pay_len} + 17'd4;
						phase = tlvp_pkg::PH_CAT;
					end
				end
			endcase
		end
		r.header_match = pre_ok;
		if (halted)
			r.parse_status = tlvp_pkg::STATUS_OVER_LIMIT;
		else if (eos && phase != tlvp_pkg::PH_CAT)
			r.parse_status = tlvp_pkg::STATUS_TRUNCATED;
		else
			r.parse_status = tlvp_pkg::STATUS_OK;
		if (eos) begin
			r.sum_zero = (run_sum == 8'd0);
			// Stream over: parse state back to reset, registers kept.
			phase    = tlvp_pkg::PH_HEADER;
			hdr_pos  = 0;
			pay_left = '0;
			pay_len  = '0;
			len_hi   = '0;
			run_sum  = '0;
			pre_ok   = 1'b1;
			halted   = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result side: random back-pressure and in-order comparison
	// ------------------------------------------------------------------------
	always @(posedge clk)
		result_ready <= ($urandom_range(0, 99) >= sink_idle_pct);

	task automatic check_field(input string name, input logic [16:0] want,
		input logic [16:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted result transaction with the oldest tag due.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_tags.size() == 0) begin
				$error("result transaction with nothing due: byte_out %0h", result.byte_out);
				mismatches++;
			end else begin
				head_tag = due_tags.pop_front();
				check_field("byte_out", 17'(head_tag.byte_out), 17'(result.byte_out));
				check_field("byte_role", 17'(head_tag.byte_role), 17'(result.byte_role));
				check_field("record_done", 17'(head_tag.record_done),
					17'(result.record_done));
				check_field("record_total_length", head_tag.record_total_length,
					result.record_total_length);
				check_field("header_match", 17'(head_tag.header_match),
					17'(result.header_match));
				check_field("parse_status", 17'(head_tag.parse_status),
					17'(result.parse_status));
				check_field("stream_done", 17'(head_tag.stream_done),
					17'(result.stream_done));
				check_field("sum_zero", 17'(head_tag.sum_zero), 17'(result.sum_zero));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Byte side: one transaction per call, valid held until accepted
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic eos);
		// Drop valid only when a gap is taken, so it is never lowered and
		// raised again within one time step.
		if ($urandom_range(0, 99) < src_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, end_of_stream: eos};
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		due_tags.push_back(tag_byte(b, eos));
		items_sent++;
	endtask

	// Send a whole stream; the last byte carries the end-of-stream flag.
	task automatic send_stream(input byte_q_t s);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	// Hold the byte side idle until every due result has come back.
	task automatic drain();
		item_valid <= 1'b0;
		while (due_tags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write transaction; valid is left high for the next one.
	task automatic write_reg(input logic [tlvp_pkg::CFG_INDEX_W-1:0] idx,
		input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			tlvp_pkg::REG_MAX_PAYLOAD_LENGTH: cfg_max_len  = data[15:0];
			tlvp_pkg::REG_PREAMBLE_WORD:      cfg_preamble = data;
			default: ;
		endcase
	endtask

	// Reconfigure while idle; unused upper bits and an out-of-map index ride along.
	task automatic set_config(input logic [15:0] max_len, input logic [23:0] preamble);
		drain();
		write_reg(tlvp_pkg::REG_MAX_PAYLOAD_LENGTH, {8'($urandom), max_len});
		write_reg(REG_UNUSED, 24'($urandom));
		write_reg(tlvp_pkg::REG_PREAMBLE_WORD, preamble);
		cfg_valid <= 1'b0;
	endtask

	// Overwrite byte k so that the 8-bit sum of the stream wraps to zero.
	function automatic byte_q_t zero_sum_at(input byte_q_t s, input int k);
		logic [7:0] sum;
		s[k] = 8'd0;
		sum = 8'd0;
		foreach (s[i])
			sum = sum + s[i];
		s[k] = -sum;
		return s;
	endfunction

	// Well-formed stream with random content, sometimes broken on purpose.
	function automatic byte_q_t make_record_stream();
		byte_q_t     s;
		logic [7:0]  b;
		logic [15:0] len;
		int          n_rec;
		int          pick;
		int          cut;
		int          limit;
		bit          over;
		limit = int'(cfg_max_len);
		for (int i = 0; i < tlvp_pkg::PREAMBLE_BYTES; i++) begin
			b = cfg_preamble[(tlvp_pkg::PREAMBLE_BYTES - 1 - i) * 8 +: 8];
			if ($urandom_range(0, 11) == 0)
				b = 8'($urandom);
			s.push_back(b);
		end
		for (int i = tlvp_pkg::PREAMBLE_BYTES; i < tlvp_pkg::HEADER_BYTES; i++)
			s.push_back(8'($urandom));
		n_rec = $urandom_range(0, 4);
		over = 1'b0;
		for (int r = 0; r < n_rec && !over; r++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = 16'($urandom_range(0, (limit < 8) ? limit : 8));
			else if (pick < 80)
				len = (limit <= 64) ? 16'(limit) : 16'($urandom_range(0, 64));
			else if (pick < 92 && limit != 16'hFFFF) begin
				len = 16'($urandom_range(limit + 1, 16'hFFFF));
				over = 1'b1;
			end else
				len = 16'($urandom_range(0, (limit < 32) ? limit : 32));
			s.push_back(8'($urandom));
			s.push_back(8'($urandom));
			s.push_back(len[15:8]);
			s.push_back(len[7:0]);
			// Past the limit the tail is ignored; keep it short.
			if (over)
				repeat ($urandom_range(0, 3)) s.push_back(8'($urandom));
			else
				repeat (len) s.push_back(8'($urandom));
		end
		if ($urandom_range(0, 3) == 0) begin
			cut = $urandom_range(1, s.size());
			while (s.size() > cut) void'(s.pop_back());
		end
		if ($urandom_range(0, 1) == 1)
			s = zero_sum_at(s, (s.size() > FREE_HDR_BYTE) ? FREE_HDR_BYTE : s.size() - 1);
		return s;
	endfunction

	function automatic byte_q_t make_noise_stream();
		byte_q_t s;
		repeat ($urandom_range(1, 12)) s.push_back(8'($urandom));
		return s;
	endfunction

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Good preamble, a zero-length record, a one-byte record, checksum to zero.
	task automatic test_framed_records();
		byte_q_t s;
		s = '{8'h4B, 8'h4E, 8'h47, 8'h00, 8'hFF, 8'h00,
			8'hFF, 8'h00, 8'h00, 8'h00,
			8'h01, 8'hFF, 8'h00, 8'h01, 8'hAA};
		send_stream(zero_sum_at(s, FREE_HDR_BYTE));
	endtask

	// One-byte stream: preamble miss and end inside the header.
	task automatic test_short_stream();
		byte_q_t s;
		s = '{8'h00};
		send_stream(s);
	endtask

	// Length one past the reset limit: stop, then ignore the final byte.
	task automatic test_length_over_limit();
		byte_q_t s;
		s = '{8'h4B, 8'h4E, 8'h47, 8'h12, 8'h34, 8'h56,
			8'h80, 8'h7F, 8'h06, 8'h33, 8'h5A};
		send_stream(s);
	endtask

	// Mostly framed streams with random content plus noise, one configuration.
	task automatic run_segment(input logic [15:0] max_len, input logic [23:0] preamble);
		int stop_at;
		set_config(max_len, preamble);
		stop_at = items_sent + SEGMENT_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 85)
				send_stream(make_record_stream());
			else
				send_stream(make_noise_stream());
		end
	endtask

	// Random traffic over the three idling modes and the register extremes.
	task automatic test_random_streams();
		set_idling(27, 51);
		run_segment(16'd16, 24'($urandom));
		run_segment(tlvp_pkg::MAX_LEN_RESET, tlvp_pkg::PREAMBLE_RESET);
		set_idling(51, 27);
		run_segment(16'h0000, 24'h000000);
		run_segment(16'hFFFF, 24'hFFFFFF);
		set_idling(0, 0);
		run_segment(16'($urandom_range(0, 63)), 24'($urandom));
		run_segment(16'($urandom), 24'($urandom));
	endtask

	initial begin
		// Hold reset, then release it on an edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(27, 51);
		test_framed_records();
		test_short_stream();
		test_length_over_limit();
		test_random_streams();

		// Let the last results drain, then idle before reporting.
		drain();
		if (mismatches == 0)
			$display("** tlv_record_stream_parser_unit: PASSED **");
		else
			$display("** tlv_record_stream_parser_unit: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
design/tlvp_pkg.sv
design/tlvp_cfg_regs.sv
design/tlvp_parse_core.sv
design/tlv_record_stream_parser_unit.sv
tb/tb.sv
